// ===== hw/rtl/rau_pkg.sv =====
// Package for the rational arithmetic unit: widths, operation codes,
// payload structs and controller/datapath command types. No dependencies.
package rau_pkg;
	localparam int OPERAND_WIDTH = 16;
	localparam int OUT_WIDTH = 32;
	// exact intermediate width: products of two operands plus a sum bit
	localparam int MAG_WIDTH = 2 * OPERAND_WIDTH + 1;
	localparam int CNT_WIDTH = $clog2(MAG_WIDTH + 1);

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_MUL_ALT = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic signed [OPERAND_WIDTH-1:0] num_a;
		logic signed [OPERAND_WIDTH-1:0] den_a;
		logic signed [OPERAND_WIDTH-1:0] num_b;
		logic signed [OPERAND_WIDTH-1:0] den_b;
	} in_item_t;

	typedef struct packed {
		logic signed [OUT_WIDTH-1:0] num_out;
		logic signed [OUT_WIDTH-1:0] den_out;
	} out_item_t;

	typedef struct packed {
		logic load;       // capture operands
		logic prod1;      // first product pair
		logic prod2;      // sum the pair into n, form m = b*d
		logic gcd_seed;   // load gcd operands x=|n|, y=|m|
		logic gcd_step;   // one Euclid remainder bit-step
		logic gcd_swap;   // finish one remainder: x <= y, y <= r
		logic div_init;   // set up the two quotient divisions
		logic div_step;   // one restoring bit-step on both
		logic finish;     // apply signs, fill output register
	} rau_cmd_t;

	typedef struct packed {
		logic y_zero;
	} rau_sts_t;
endpackage

// ===== hw/rtl/rational_arith_unit.sv =====
// Rational arithmetic unit top level: controller plus datapath.
// Sequence: load, two product states, gcd seed, then one Euclid remainder per pass
// (33 bit-steps, then a swap), 33 quotient bit-steps on both quotients, finish, hold.
// Throughput: one item at a time; the next input is accepted only after the result
// transfer (out_valid with out_ready), so output stalls hold the next item off.
// Reset (arst_n, async, active low) returns the controller to idle.
module rational_arith_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  rau_pkg::in_item_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output rau_pkg::out_item_t out_data
);
	rau_pkg::rau_cmd_t cmd;
	rau_pkg::rau_sts_t sts;

	// sequence the datapath
	rau_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
	);

	// arithmetic, gcd and quotient units
	rau_datapath u_dp (
		.clk(clk), .in_item(in_data), .cmd(cmd), .sts(sts), .res(out_data)
	);
endmodule

// ===== hw/rtl/rau_datapath.sv =====
// Datapath of the rational arithmetic unit: products, bit-serial Euclid gcd,
// two bit-serial quotient units. Depends on rau_pkg.
module rau_datapath (
	input  logic clk,
	input  rau_pkg::in_item_t in_item,
	input  rau_pkg::rau_cmd_t cmd,
	output rau_pkg::rau_sts_t sts,
	output rau_pkg::out_item_t res
);
	localparam int W = rau_pkg::MAG_WIDTH;
	localparam int OW = rau_pkg::OPERAND_WIDTH;

	logic signed [OW-1:0] a_q, b_q, c_q, d_q;
	logic [1:0] op_q;
	logic signed [2*OW-1:0] p0_q, p1_q;
	logic signed [W-1:0] n_q;
	logic signed [2*OW-1:0] m_q;
	logic n_neg_q, m_neg_q;
	logic [W-1:0] x_q, y_q, rem_q, nq_q, mq_q, nr_q, mr_q, g_q;
	logic [W-1:0] gx_q; // dividend bits being shifted out in gcd
	logic signed [2*OW-1:0] p0_d, p1_d;
	logic [W:0] rem_sh, nr_sh, mr_sh;
	logic [W-1:0] n_mag, m_mag;

	always_comb begin
		if (op_q[1]) begin
			p0_d = a_q * c_q;
			p1_d = '0;
		end else begin
			p0_d = a_q * d_q;
			// negate the full cross product, so a most negative c stays exact
			p1_d = (op_q == rau_pkg::OP_SUB) ? -(b_q * c_q) : b_q * c_q;
		end
		n_mag = n_q[W-1] ? W'(-n_q) : W'(n_q);
		m_mag = m_q[2*OW-1] ? W'(-{m_q[2*OW-1], m_q}) : W'({m_q[2*OW-1], m_q});
		rem_sh = {rem_q, gx_q[W-1]};
		nr_sh = {nr_q, nq_q[W-1]};
		mr_sh = {mr_q, mq_q[W-1]};
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_item.req_type;
			a_q <= in_item.num_a;
			b_q <= in_item.den_a;
			c_q <= in_item.num_b;
			d_q <= in_item.den_b;
		end
		if (cmd.prod1) begin
			p0_q <= p0_d;
			p1_q <= p1_d;
		end
		if (cmd.prod2) begin
			n_q <= W'(p0_q) + W'(p1_q);
			m_q <= b_q * d_q;
		end
		if (cmd.gcd_seed) begin
			x_q <= n_mag;
			y_q <= m_mag;
			gx_q <= n_mag;
			rem_q <= '0;
		end else if (cmd.gcd_swap) begin
			x_q <= y_q;
			y_q <= rem_q;
			gx_q <= y_q;
			rem_q <= '0;
		end else if (cmd.gcd_step) begin
			gx_q <= {gx_q[W-2:0], 1'b0};
			rem_q <= (rem_sh >= {1'b0, y_q}) ? W'(rem_sh - {1'b0, y_q}) : rem_sh[W-1:0];
		end
		if (cmd.finish) begin
			res.num_out <= n_neg_q ? -nq_q[rau_pkg::OUT_WIDTH-1:0]
				: nq_q[rau_pkg::OUT_WIDTH-1:0];
			res.den_out <= m_neg_q ? -mq_q[rau_pkg::OUT_WIDTH-1:0]
				: mq_q[rau_pkg::OUT_WIDTH-1:0];
		end
		if (cmd.div_step) begin
			nq_q <= {nq_q[W-2:0], (nr_sh >= {1'b0, g_q})};
			mq_q <= {mq_q[W-2:0], (mr_sh >= {1'b0, g_q})};
			nr_q <= (nr_sh >= {1'b0, g_q}) ? W'(nr_sh - {1'b0, g_q}) : nr_sh[W-1:0];
			mr_q <= (mr_sh >= {1'b0, g_q}) ? W'(mr_sh - {1'b0, g_q}) : mr_sh[W-1:0];
		end else if (cmd.div_init) begin
			g_q <= (x_q == '0) ? W'(1) : x_q;
			nq_q <= n_mag;
			mq_q <= m_mag;
			nr_q <= '0;
			mr_q <= '0;
			n_neg_q <= n_q[W-1];
			m_neg_q <= m_q[2*OW-1];
		end
	end

	assign sts.y_zero = (y_q == '0);
endmodule

// ===== hw/rtl/rau_ctrl.sv =====
// Controller of the rational arithmetic unit: handshake and sequencing of
// the datapath. Depends on rau_pkg.
module rau_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  rau_pkg::rau_sts_t sts,
	output rau_pkg::rau_cmd_t cmd
);
	localparam int W = rau_pkg::MAG_WIDTH;
	localparam int CW = rau_pkg::CNT_WIDTH;
	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_PROD1 = 8'b0000_0010,
		S_PROD2 = 8'b0000_0100,
		S_SEED = 8'b0000_1000,
		S_GCD = 8'b0001_0000,
		S_DIV = 8'b0010_0000,
		S_DONE = 8'b0100_0000,
		S_HOLD = 8'b1000_0000
	} state_t;
	state_t state_q;
	logic [CW-1:0] cnt_q;
	logic cnt_last;
	logic gcd_last;
	// W quotient steps end at W-1; W remainder steps are followed by the swap
	assign cnt_last = (cnt_q == CW'(W - 1));
	assign gcd_last = (cnt_q == CW'(W));

	always_comb begin
		cmd = '0;
		in_ready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: cmd.load = in_valid;
			S_PROD1: cmd.prod1 = 1'b1;
			S_PROD2: cmd.prod2 = 1'b1;
			S_SEED: cmd.gcd_seed = 1'b1;
			S_GCD: begin
				if (sts.y_zero) cmd.div_init = 1'b1;
				else if (gcd_last) cmd.gcd_swap = 1'b1;
				else cmd.gcd_step = 1'b1;
			end
			S_DIV: cmd.div_step = 1'b1;
			S_DONE: cmd.finish = 1'b1;
			S_HOLD: ;
			default: ;
		endcase
	end

	assign out_valid = (state_q == S_HOLD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_PROD1;
				S_PROD1: state_q <= S_PROD2;
				S_PROD2: state_q <= S_SEED;
				S_SEED: begin
					state_q <= S_GCD;
					cnt_q <= '0;
				end
				S_GCD: begin
					if (sts.y_zero) begin
						state_q <= S_DIV;
						cnt_q <= '0;
					end else if (gcd_last) cnt_q <= '0;
					else cnt_q <= cnt_q + 1'b1;
				end
				S_DIV: begin
					if (cnt_last) state_q <= S_DONE;
					cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
				end
				S_DONE: state_q <= S_HOLD;
				S_HOLD: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("overlap");
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_PROD1) else $error("load");
endmodule

// ===== verif/tb_rational_arith_unit.sv =====
// Testbench for rational_arith_unit: random and directed fraction add, subtract
// and multiply transfers, checked against an in-bench gcd-reducing predictor.
// Depends on rau_pkg and the rational_arith_unit RTL.
module tb_rational_arith_unit;
	timeunit 1ns;
	timeprecision 1ps;

	// Expected reduced fractions, oldest first; counts mismatches.
	class fraction_scoreboard;
		rau_pkg::out_item_t pending[$];
		int errors;
		int checked;

		// Reduce a signed magnitude pair by Euclid on absolute values.
		function rau_pkg::out_item_t reduce(rau_pkg::in_item_t it);
			longint a, b, c, d, n, m, x, y, t;
			rau_pkg::out_item_t r;
			a = it.num_a;
			b = it.den_a;
			c = it.num_b;
			d = it.den_b;
			if (it.req_type[1]) begin
				n = a * c;
			end else begin
				if (it.req_type[0]) c = -c;
				n = a * d + b * c;
			end
			m = b * d;
			x = (n < 0) ? -n : n;
			y = (m < 0) ? -m : m;
			while (y != 0) begin
				t = x % y;
				x = y;
				y = t;
			end
			if (x == 0) x = 1;
			n = n / x;
			m = m / x;
			r.num_out = n[31:0];
			r.den_out = m[31:0];
			return r;
		endfunction

		function void note_input(rau_pkg::in_item_t it);
			pending.push_back(reduce(it));
		endfunction

		function void check_result(rau_pkg::out_item_t got);
			rau_pkg::out_item_t want;
			if (pending.size() == 0) begin
				$error("unexpected result num_out=%0d den_out=%0d",
					got.num_out, got.den_out);
				errors++;
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got.num_out !== want.num_out) begin
				$error("num_out: expected %0d, got %0d", want.num_out, got.num_out);
				errors++;
			end
			if (got.den_out !== want.den_out) begin
				$error("den_out: expected %0d, got %0d", want.den_out, got.den_out);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	rau_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rau_pkg::out_item_t out_data;

	fraction_scoreboard fractions;
	int send_idle_pct = 0;   // percent of cycles the sender holds off
	int recv_idle_pct = 0;   // percent of cycles the receiver stalls
	int hold_off_cycles = 0; // long receiver stall, counted below
	int sent = 0;

	always #4 clk = ~clk;

	rational_arith_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	// Note inputs and check results at the edge where each transfer happens.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) fractions.note_input(in_data);
		if (arst_n && out_valid && out_ready) fractions.check_result(out_data);
	end

	// Receiver: stall at random, or hold off for a counted long stretch.
	always @(posedge clk) begin
		if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Operand pick: full random four times in ten, else extremes, small or zero.
	function automatic logic [15:0] pick_operand();
		case ($urandom_range(9))
			0: return 16'sh8000;
			1: return 16'sd32767;
			2: return -16'sd32767;
			3: return 16'd0;
			4, 5: return 16'($signed($urandom_range(24)) - 12);
			default: return 16'($urandom);
		endcase
	endfunction

	// Offer one transfer and hold it until accepted; drop valid while idling.
	task automatic send_fraction(rau_pkg::op_t op, logic [15:0] a, logic [15:0] b,
			logic [15:0] c, logic [15:0] d);
		rau_pkg::in_item_t it;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		it.req_type = op;
		it.num_a = a;
		it.den_a = b;
		it.num_b = c;
		it.den_b = d;
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
	endtask

	task automatic send_random(int count);
		repeat (count) begin
			send_fraction(rau_pkg::op_t'($urandom_range(3)), pick_operand(),
				pick_operand(), pick_operand(), pick_operand());
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (fractions.pending.size() != 0) @(posedge clk);
	endtask

	initial begin
		fractions = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: each operation, extremes, zero denominators, 0/0.
		send_fraction(rau_pkg::OP_ADD, 16'd1, 16'd2, 16'd1, 16'd3);
		send_fraction(rau_pkg::OP_SUB, 16'd1, 16'd2, 16'd1, 16'd3);
		send_fraction(rau_pkg::OP_MUL, 16'd2, 16'd3, 16'd3, 16'd4);
		send_fraction(rau_pkg::OP_MUL_ALT, -16'sd2, 16'd3, 16'd3, -16'sd4);
		send_fraction(rau_pkg::OP_SUB, 16'd5, 16'd7, 16'd5, 16'd7);
		send_fraction(rau_pkg::OP_ADD, 16'd3, 16'd0, 16'd1, 16'd5);
		send_fraction(rau_pkg::OP_MUL, -16'sd9, 16'd0, 16'd1, 16'd5);
		send_fraction(rau_pkg::OP_ADD, 16'd0, 16'd0, 16'd0, 16'd0);
		send_fraction(rau_pkg::OP_MUL, 16'd0, 16'd4, 16'd7, 16'd0);
		send_fraction(rau_pkg::OP_ADD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
		send_fraction(rau_pkg::OP_SUB, 16'sh8000, 16'd1, 16'sh8000, 16'sh8000);
		send_fraction(rau_pkg::OP_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'd1);
		send_fraction(rau_pkg::OP_ADD, 16'd32767, 16'd32766, 16'd32767, 16'd32765);
		send_fraction(rau_pkg::OP_SUB, -16'sd32767, 16'd32767, 16'd32767, -16'sd32767);
		send_fraction(rau_pkg::OP_MUL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_fraction(rau_pkg::OP_ADD, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
		send_fraction(rau_pkg::OP_MUL_ALT, 16'h7FFF, 16'h8001, 16'h0001, 16'h7FFF);
		drain();

		// Long receiver hold-off while five items are sent; then wait until every result is in.
		hold_off_cycles = 2000;
		send_random(5);
		drain();

		send_idle_pct = 13;
		recv_idle_pct = 81;
		send_random(340);
		drain();
		send_idle_pct = 81;
		recv_idle_pct = 13;
		send_random(340);
		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random(340);
		drain();
		repeat (200) @(posedge clk);

		$display("covered add, subtract, multiply and the unused code, zero and");
		$display("extreme operands; %0d results checked under varied stalls",
			fractions.checked);
		if (fractions.errors == 0 && fractions.pending.size() == 0) begin
			$display("tb_rational_arith_unit: done, clean");
		end else begin
			$display("tb_rational_arith_unit: done, errors");
		end
		$finish;
	end

	// Watchdog for a hung run of 1042 items with stalls; reports errors and ends.
	initial begin
		#80ms;
		$display("tb_rational_arith_unit: done, errors");
		$finish;
	end
endmodule

// ===== rational_arith_unit.f =====
hw/rtl/rau_pkg.sv
hw/rtl/rau_datapath.sv
hw/rtl/rau_ctrl.sv
hw/rtl/rational_arith_unit.sv
verif/tb_rational_arith_unit.sv
